// ===== src/ajt_pkg.sv =====
// ----------------------------------------------------------------------------
// ajt_pkg
// Shared types and codes of the ancestor jump table: request and status codes,
// configuration register indexes and widths, controller-datapath interface.
// ----------------------------------------------------------------------------
package ajt_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int MAX_LEVELS_DEF = 11;

    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 11;
    localparam int NODE_COUNT_W  = 11;
    localparam int LEVEL_NUM_W   = 4;

    localparam int NODE_COUNT_RST = 1024;
    localparam int LEVEL_NUM_RST  = 11;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LEVEL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_NUM  = 1'd1;

    typedef struct packed {
        logic rd_req;
        logic wr_req;
        logic out_imm;
        logic out_query;
        logic out_build;
        logic bld_start;
        logic bld_rd1;
        logic bld_rd2;
        logic bld_wr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic write_ok;
        logic query_ok;
        logic bld_empty;
        logic bld_last;
    } stat_t;

endpackage

// ===== src/ajt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ajt_ctrl
// Sequencer of the ancestor jump table: accepts items, steps queries and the
// level build, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ajt_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ajt_pkg::REQ_W-1:0]   req_type,
    input  ajt_pkg::stat_t              stat,
    output ajt_pkg::cmd_t               cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QOUT  = 3'd1;
    localparam logic [2:0] S_BRD1  = 3'd2;
    localparam logic [2:0] S_BRD2  = 3'd3;
    localparam logic [2:0] S_BWR   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_ready && in_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        ajt_pkg::REQ_WRITE:
                        begin
                            cmd.wr_req  = stat.write_ok;
                            cmd.out_imm = 1'b1;
                        end
                        ajt_pkg::REQ_BUILD:
                        begin
                            if (stat.bld_empty)
                            begin
                                cmd.out_build = 1'b1;
                            end
                            else
                            begin
                                cmd.bld_start = 1'b1;
                                state_next    = S_BRD1;
                            end
                        end
                        ajt_pkg::REQ_QUERY:
                        begin
                            if (stat.query_ok)
                            begin
                                cmd.rd_req = 1'b1;
                                state_next = S_QOUT;
                            end
                            else
                            begin
                                cmd.out_imm = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.out_imm = 1'b1;
                        end
                    endcase
                end
            end
            S_QOUT:
            begin
                cmd.out_query = 1'b1;
                state_next    = S_IDLE;
            end
            S_BRD1:
            begin
                cmd.bld_rd1 = 1'b1;
                state_next  = S_BRD2;
            end
            S_BRD2:
            begin
                cmd.bld_rd2 = 1'b1;
                state_next  = S_BWR;
            end
            S_BWR:
            begin
                cmd.bld_wr = 1'b1;
                if (stat.bld_last)
                begin
                    cmd.out_build = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_BRD1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/ajt_datapath.sv =====
// ----------------------------------------------------------------------------
// ajt_datapath
// Datapath of the ancestor jump table: table memory, configuration and built
// mark, request checks, build counters and the result register.
// ----------------------------------------------------------------------------
module ajt_datapath
#(
    parameter  int MAX_NODES  = ajt_pkg::MAX_NODES_DEF,
    parameter  int MAX_LEVELS = ajt_pkg::MAX_LEVELS_DEF,
    localparam int NODE_W     = $clog2(MAX_NODES),
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ajt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ajt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [ajt_pkg::REQ_W-1:0]         req_type,
    input  logic [NODE_W-1:0]                 node_index,
    input  logic [NODE_W-1:0]                 parent_value,
    input  logic [LVL_W-1:0]                  level_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [NODE_W-1:0]                 ancestor,
    output logic [ajt_pkg::STATUS_W-1:0]      status,
    input  ajt_pkg::cmd_t                     cmd,
    output ajt_pkg::stat_t                    stat
);

    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int DEPTH   = MAX_LEVELS * MAX_NODES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NODES_RST  = (ajt_pkg::NODE_COUNT_RST > MAX_NODES) ?
                                MAX_NODES : ajt_pkg::NODE_COUNT_RST;
    localparam int LEVELS_RST = (ajt_pkg::LEVEL_NUM_RST > MAX_LEVELS) ?
                                MAX_LEVELS : ajt_pkg::LEVEL_NUM_RST;

    logic [NODE_W-1:0] jump_mem [DEPTH];
    logic [NODE_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  nodes_reg;
    logic [CNT_W-1:0]  nodes_next;
    logic [LVL_W-1:0]  levels_reg;
    logic [LVL_W-1:0]  levels_next;
    logic              built_reg;
    logic              built_next;
    logic [LVL_W-1:0]  k_reg;
    logic [LVL_W-1:0]  k_next;
    logic [NODE_W-1:0] i_reg;
    logic [NODE_W-1:0] i_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [NODE_W-1:0] anc_reg;
    logic [NODE_W-1:0] anc_next;
    logic [ajt_pkg::STATUS_W-1:0] status_reg;
    logic [ajt_pkg::STATUS_W-1:0] status_next;

    logic [ajt_pkg::NODE_COUNT_W-1:0] nc_raw;
    logic [ajt_pkg::LEVEL_NUM_W-1:0]  lc_raw;
    logic [CNT_W-1:0]  nodes_cfg;
    logic [LVL_W-1:0]  levels_cfg;

    logic              node_bad;
    logic              parent_bad;
    logic              level_bad;
    logic              unbuilt;
    logic [ajt_pkg::STATUS_W-1:0] imm_status;
    logic              i_last;
    logic [LVL_W-1:0]  k_prev;

    logic              mem_re;
    logic              mem_we;
    logic [LVL_W-1:0]  rd_level;
    logic [NODE_W-1:0] rd_node;
    logic [LVL_W-1:0]  wr_level;
    logic [NODE_W-1:0] wr_node;
    logic [NODE_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign ancestor  = anc_reg;
    assign status    = status_reg;

    assign nc_raw     = cfg_data[ajt_pkg::NODE_COUNT_W-1:0];
    assign lc_raw     = cfg_data[ajt_pkg::LEVEL_NUM_W-1:0];
    assign nodes_cfg  = (32'(nc_raw) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(nc_raw);
    assign levels_cfg = (lc_raw == '0) ? LVL_W'(1) :
                        (32'(lc_raw) > 32'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : LVL_W'(lc_raw);

    assign node_bad   = CNT_W'(node_index) >= nodes_reg;
    assign parent_bad = CNT_W'(parent_value) >= nodes_reg;
    assign level_bad  = level_index >= levels_reg;
    assign unbuilt    = (level_index != '0) && !built_reg;

    always_comb
    begin
        case (req_type)
            ajt_pkg::REQ_WRITE:
            begin
                imm_status = (node_bad || parent_bad) ? ajt_pkg::ST_RANGE : ajt_pkg::ST_OK;
            end
            ajt_pkg::REQ_QUERY:
            begin
                if (node_bad)
                begin
                    imm_status = ajt_pkg::ST_RANGE;
                end
                else if (level_bad)
                begin
                    imm_status = ajt_pkg::ST_LEVEL;
                end
                else if (unbuilt)
                begin
                    imm_status = ajt_pkg::ST_UNBUILT;
                end
                else
                begin
                    imm_status = ajt_pkg::ST_OK;
                end
            end
            default:
            begin
                imm_status = ajt_pkg::ST_OK;
            end
        endcase
    end

    assign k_prev = k_reg - LVL_W'(1);
    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == nodes_reg;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.write_ok  = !node_bad && !parent_bad;
    assign stat.query_ok  = !node_bad && !level_bad && !unbuilt;
    assign stat.bld_empty = (nodes_reg == '0) || (levels_reg == LVL_W'(1));
    assign stat.bld_last  = i_last && (k_reg == levels_reg - LVL_W'(1));

    always_comb
    begin
        mem_re   = cmd.rd_req || cmd.bld_rd1 || cmd.bld_rd2;
        rd_level = k_prev;
        rd_node  = i_reg;
        if (cmd.rd_req)
        begin
            rd_level = level_index;
            rd_node  = node_index;
        end
        else if (cmd.bld_rd2)
        begin
            rd_node = rd_data_reg;
        end
        mem_we   = cmd.wr_req || cmd.bld_wr;
        wr_level = k_reg;
        wr_node  = i_reg;
        wr_data  = rd_data_reg;
        if (cmd.wr_req)
        begin
            wr_level = '0;
            wr_node  = node_index;
            wr_data  = parent_value;
        end
    end

    assign rd_addr = ADDR_W'(rd_level) * ADDR_W'(MAX_NODES) + ADDR_W'(rd_node);
    assign wr_addr = ADDR_W'(wr_level) * ADDR_W'(MAX_NODES) + ADDR_W'(wr_node);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            jump_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= jump_mem[rd_addr];
        end
    end

    always_comb
    begin
        nodes_next  = nodes_reg;
        levels_next = levels_reg;
        built_next  = built_reg;
        if (cfg_valid)
        begin
            built_next = 1'b0;
            case (cfg_index)
                ajt_pkg::CFG_NODE_COUNT:
                begin
                    nodes_next = nodes_cfg;
                end
                ajt_pkg::CFG_LEVEL_NUM:
                begin
                    levels_next = levels_cfg;
                end
                default:
                begin
                    built_next = 1'b0;
                end
            endcase
        end
        if (cmd.wr_req)
        begin
            built_next = 1'b0;
        end
        if (cmd.out_build)
        begin
            built_next = 1'b1;
        end
    end

    always_comb
    begin
        k_next = k_reg;
        i_next = i_reg;
        if (cmd.bld_start)
        begin
            k_next = LVL_W'(1);
            i_next = '0;
        end
        else if (cmd.bld_wr)
        begin
            if (i_last)
            begin
                i_next = '0;
                k_next = k_reg + LVL_W'(1);
            end
            else
            begin
                i_next = i_reg + NODE_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        anc_next       = anc_reg;
        status_next    = status_reg;
        if (cmd.out_imm)
        begin
            out_valid_next = 1'b1;
            anc_next       = '0;
            status_next    = imm_status;
        end
        else if (cmd.out_query)
        begin
            out_valid_next = 1'b1;
            anc_next       = rd_data_reg;
            status_next    = ajt_pkg::ST_OK;
        end
        else if (cmd.out_build)
        begin
            out_valid_next = 1'b1;
            anc_next       = '0;
            status_next    = ajt_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg     <= CNT_W'(NODES_RST);
            levels_reg    <= LVL_W'(LEVELS_RST);
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nodes_reg     <= nodes_next;
            levels_reg    <= levels_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        i_reg      <= i_next;
        anc_reg    <= anc_next;
        status_reg <= status_next;
    end

endmodule

// ===== src/ancestor_jump_table.sv =====
// ----------------------------------------------------------------------------
// ancestor_jump_table
// Binary-lifting ancestor table with parent writes, level build and queries.
// ----------------------------------------------------------------------------
// A write or a rejected request goes straight to the result register, while
// a valid query first reads the table and then loads the result: the table
// is a single-port-read memory whose read data is registered. A build holds
// the block busy while it steps through each entry of each level above level
// 0; each entry needs two dependent reads of the table through that one read
// port and one write. The table has no reset and no clearing pass; an
// entry must be written before it is queried or built from. Configuration
// writes are always taken and clear the built mark.
module ancestor_jump_table
#(
    parameter  int MAX_NODES  = ajt_pkg::MAX_NODES_DEF,
    parameter  int MAX_LEVELS = ajt_pkg::MAX_LEVELS_DEF,
    localparam int NODE_W     = $clog2(MAX_NODES),
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ajt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ajt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ajt_pkg::REQ_W-1:0]         req_type,
    input  logic [NODE_W-1:0]                 node_index,
    input  logic [NODE_W-1:0]                 parent_value,
    input  logic [LVL_W-1:0]                  level_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [NODE_W-1:0]                 ancestor,
    output logic [ajt_pkg::STATUS_W-1:0]      status
);

    ajt_pkg::cmd_t  cmd;
    ajt_pkg::stat_t stat;

    ajt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    ajt_datapath
    #(
        .MAX_NODES  (MAX_NODES),
        .MAX_LEVELS (MAX_LEVELS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .node_index   (node_index),
        .parent_value (parent_value),
        .level_index  (level_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ancestor     (ancestor),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
